// ===== rtl/tkmd_pkg.sv =====
package tkmd_pkg;

    // Field widths
    localparam int CID_W        = 61;
    localparam int ID_W         = 60;
    localparam int DIST_W       = 32;
    localparam int RC_W         = 7;
    localparam int CENTROID_BIT = 60;

    // Register reset and default list depth
    localparam logic [RC_W-1:0] RC_RESET = 7'd10;
    localparam int MAX_RESULTS_DEF = 64;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // One classified request handed from front to back
    typedef struct packed {
        logic [DIST_W-1:0] dist_bits;
        logic [ID_W-1:0]   id;
        logic              keep;
        logic              last;
    } q_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_EMIT
    } back_state_t;

endpackage

// ===== rtl/tkmd_front.sv =====
module tkmd_front
    import tkmd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CID_W-1:0]  s_candidate_id,
    input  logic [DIST_W-1:0] s_distance_bits,
    input  logic              s_slot_empty,
    input  logic              s_last_candidate,
    output logic              q_valid,
    input  logic              q_ready,
    output q_entry_t          q_entry
);

    q_entry_t       q_mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   q_cnt_reg, q_cnt_next;
    logic           keep;
    logic           push;
    logic           pop;
    q_entry_t       in_entry;

    // drop empty slots and centroid entries; a dropped request still goes
    // through when it closes the query
    assign keep = !s_slot_empty && !s_candidate_id[CENTROID_BIT];

    always_comb begin
        in_entry.dist_bits = s_distance_bits;
        in_entry.id        = s_candidate_id[ID_W-1:0];
        in_entry.keep      = keep;
        in_entry.last      = s_last_candidate;
    end

    assign s_ready = (q_cnt_reg != (QAW+1)'(QDEPTH));
    assign q_valid = (q_cnt_reg != '0);
    assign q_entry = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready && (keep || s_last_candidate);
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QAW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QAW'(1);
        end
        if (push && !pop) begin
            q_cnt_next = q_cnt_reg + (QAW+1)'(1);
        end else if (pop && !push) begin
            q_cnt_next = q_cnt_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ===== rtl/tkmd_back.sv =====
module tkmd_back
    import tkmd_pkg::*;
#(
    parameter int MAX_RESULTS = MAX_RESULTS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  q_entry_t        q_entry,
    input  logic [RC_W-1:0] result_count,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [ID_W-1:0] m_result_id,
    output logic            m_result_empty,
    output logic            m_last_result
);

    localparam int CNTW = $clog2(MAX_RESULTS + 1);
    localparam int NW   = (CNTW > RC_W) ? CNTW : RC_W;

    back_state_t       state_reg, state_next;
    q_entry_t          cur_reg, cur_next;
    logic [DIST_W-1:0] dist_reg [MAX_RESULTS];
    logic [DIST_W-1:0] dist_next [MAX_RESULTS];
    logic [ID_W-1:0]   id_reg [MAX_RESULTS];
    logic [ID_W-1:0]   id_next [MAX_RESULTS];
    logic [CNTW-1:0]   count_reg, count_next;
    logic [MAX_RESULTS-1:0] lt_reg, lt_next;
    logic [MAX_RESULTS-1:0] dupb_reg, dupb_next;
    logic              hit_reg, hit_next;
    logic              ign_reg, ign_next;
    logic [NW-1:0]     k_reg, k_next;
    logic [NW-1:0]     n_eff;
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_id_reg, m_id_next;
    logic              m_empty_reg, m_empty_next;
    logic              m_last_reg, m_last_next;

    logic              vld;
    logic              match;
    logic              run;
    logic              blk;
    logic              prev_lt;
    logic [DIST_W-1:0] prev_d;
    logic [ID_W-1:0]   prev_id;
    logic              is_last;

    assign m_valid        = m_valid_reg;
    assign m_result_id    = m_id_reg;
    assign m_result_empty = m_empty_reg;
    assign m_last_result  = m_last_reg;

    // zero counts as one, above the list depth saturates
    always_comb begin
        if (result_count == '0) begin
            n_eff = NW'(1);
        end else if (NW'(result_count) > NW'(MAX_RESULTS)) begin
            n_eff = NW'(MAX_RESULTS);
        end else begin
            n_eff = NW'(result_count);
        end
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        dist_next    = dist_reg;
        id_next      = id_reg;
        count_next   = count_reg;
        lt_next      = lt_reg;
        dupb_next    = dupb_reg;
        hit_next     = hit_reg;
        ign_next     = ign_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        m_id_next    = m_id_reg;
        m_empty_next = m_empty_reg;
        m_last_next  = m_last_reg;
        q_ready      = 1'b0;
        vld          = 1'b0;
        match        = 1'b0;
        run          = 1'b0;
        blk          = 1'b0;
        prev_lt      = 1'b1;
        prev_d       = '0;
        prev_id      = '0;
        is_last      = 1'b0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    cur_next = q_entry;
                    k_next   = '0;
                    state_next = q_entry.keep ? ST_CMP : ST_EMIT;
                end
            end
            ST_CMP: begin
                // every kept entry against the new key at once
                for (int i = 0; i < MAX_RESULTS; i++) begin
                    vld   = (CNTW'(i) < count_reg);
                    lt_next[i] = vld && ({dist_reg[i], id_reg[i]}
                                         < {cur_reg.dist_bits, cur_reg.id});
                    match = vld && (id_reg[i] == cur_reg.id);
                    dupb_next[i] = run;
                    if (match) begin
                        run = 1'b1;
                        if (!(cur_reg.dist_bits < dist_reg[i])) begin
                            blk = 1'b1;
                        end
                    end
                end
                hit_next = run;
                // ignore a repeat that is not strictly nearer, or a full list with the new key not below the tail
                ign_next = blk || (!run && (count_reg == CNTW'(MAX_RESULTS))
                           && lt_next[MAX_RESULTS-1]);
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (!ign_reg) begin
                    // below the slot: hold; at the slot: new key;
                    // between slot and old copy: shift down by one
                    for (int i = 0; i < MAX_RESULTS; i++) begin
                        if (!lt_reg[i]) begin
                            if (prev_lt) begin
                                dist_next[i] = cur_reg.dist_bits;
                                id_next[i]   = cur_reg.id;
                            end else if (!dupb_reg[i]) begin
                                dist_next[i] = prev_d;
                                id_next[i]   = prev_id;
                            end
                        end
                        prev_lt = lt_reg[i];
                        prev_d  = dist_reg[i];
                        prev_id = id_reg[i];
                    end
                    if (!hit_reg && (count_reg != CNTW'(MAX_RESULTS))) begin
                        count_next = count_reg + CNTW'(1);
                    end
                end
                state_next = cur_reg.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    is_last      = (NW'(k_reg + NW'(1)) == n_eff);
                    m_valid_next = 1'b1;
                    m_last_next  = is_last;
                    if (count_reg != '0) begin
                        m_id_next    = id_reg[0];
                        m_empty_next = 1'b0;
                        for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                            dist_next[i] = dist_reg[i+1];
                            id_next[i]   = id_reg[i+1];
                        end
                        count_next = count_reg - CNTW'(1);
                    end else begin
                        m_id_next    = '0;
                        m_empty_next = 1'b1;
                    end
                    k_next = NW'(k_reg + NW'(1));
                    if (is_last) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        dist_reg    <= dist_next;
        id_reg      <= id_next;
        lt_reg      <= lt_next;
        dupb_reg    <= dupb_next;
        hit_reg     <= hit_next;
        ign_reg     <= ign_next;
        k_reg       <= k_next;
        m_id_reg    <= m_id_next;
        m_empty_reg <= m_empty_next;
        m_last_reg  <= m_last_next;
    end

endmodule

// ===== rtl/top_k_merge_dedup.sv =====
// Streaming top-k merge with de-duplication. Candidate requests (id and raw
// IEEE single distance) enter on s_*; empty slots and centroid ids (bit 60
// set) are dropped at the front and only forwarded if they close the query.
// A four-deep queue decouples the front from the insertion list, which keeps
// up to MAX_RESULTS distinct ids sorted by (distance, id); a repeated id only
// moves when its new distance is strictly smaller. On the request marked last
// the list streams out result_count ids on m_*, nearest first, padded with
// empty results, and is then cleared. A kept candidate passes the back-end
// steps queue pop, parallel compare of all entries and shift into place; a
// dropped one that closes the query goes from its pop straight to emitting.
// The input accepts while the queue has room. result_count is written on the
// cfg_* port by the user, and only while the block is idle: the block itself
// does not enforce this. 0 reads as 1 and values above MAX_RESULTS saturate.
module top_k_merge_dedup
    import tkmd_pkg::*;
#(
    parameter int MAX_RESULTS = MAX_RESULTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // candidate requests
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CID_W-1:0]  s_candidate_id,
    input  logic [DIST_W-1:0] s_distance_bits,
    input  logic              s_slot_empty,
    input  logic              s_last_candidate,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ID_W-1:0]   m_result_id,
    output logic              m_result_empty,
    output logic              m_last_result,
    // result_count register
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RC_W-1:0]   cfg_result_count
);

    logic [RC_W-1:0] rc_reg, rc_next;
    logic            q_valid;
    logic            q_ready;
    q_entry_t        q_entry;

    // register port never stalls
    assign cfg_ready = 1'b1;
    assign rc_next   = (cfg_valid && cfg_ready) ? cfg_result_count : rc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg <= RC_RESET;
        end else begin
            rc_reg <= rc_next;
        end
    end

    // front: accept, classify, queue
    tkmd_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_candidate_id   (s_candidate_id),
        .s_distance_bits  (s_distance_bits),
        .s_slot_empty     (s_slot_empty),
        .s_last_candidate (s_last_candidate),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_entry          (q_entry)
    );

    // back: sorted insertion list and result streaming
    tkmd_back #(
        .MAX_RESULTS (MAX_RESULTS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_entry        (q_entry),
        .result_count   (rc_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_id    (m_result_id),
        .m_result_empty (m_result_empty),
        .m_last_result  (m_last_result)
    );

endmodule

// ===== rtl/tkmd_checker.sv =====
module tkmd_checker
    import tkmd_pkg::*;
#(
    parameter int MAX_RESULTS = MAX_RESULTS_DEF
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [ID_W-1:0]   m_result_id,
    input logic              m_result_empty,
    input logic              m_last_result
);

    localparam int CNTW = $clog2(MAX_RESULTS + 1);

    logic            m_take;
    logic            pad_seen_reg, pad_seen_next;
    logic [CNTW-1:0] res_cnt_reg, res_cnt_next;

    assign m_take = m_valid && m_ready;

    // padding within a query, and results taken so far in it
    always_comb begin
        pad_seen_next = pad_seen_reg;
        res_cnt_next  = res_cnt_reg;
        if (m_take) begin
            if (m_last_result) begin
                pad_seen_next = 1'b0;
                res_cnt_next  = '0;
            end else begin
                pad_seen_next = pad_seen_reg || m_result_empty;
                res_cnt_next  = CNTW'(res_cnt_reg + CNTW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_seen_reg <= 1'b0;
            res_cnt_reg  <= '0;
        end else begin
            pad_seen_reg <= pad_seen_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_id)
        && $stable(m_result_empty) && $stable(m_last_result))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_empty |-> m_result_id == '0)
        else $error("padding result carries an id");

    a_pad_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && pad_seen_reg |-> m_result_empty)
        else $error("real result after padding");

    a_max_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (res_cnt_reg == CNTW'(MAX_RESULTS - 1)) |-> m_last_result)
        else $error("query longer than list depth");

endmodule

bind top_k_merge_dedup tkmd_checker #(.MAX_RESULTS(MAX_RESULTS)) u_tkmd_checker (.*);
